[design/mersenne_twister_64_generator_core_defines.svh]
// Assertion macros used by the generator's checker file
`ifndef MERSENNE_TWISTER_64_GENERATOR_CORE_DEFINES_SVH
`define MERSENNE_TWISTER_64_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication, masked while reset is low
`define MT64_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is low
`define MT64_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset
`define MT64_ASSERT_RST(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/mt64_pkg.sv]
// Types, constants and helper functions for the 64-bit twister generator
`timescale 1ns / 1ps

package mt64_pkg;

    localparam int DEF_NUM_STREAMS = 2;

    localparam int POS_W    = 9;
    localparam int MODE_W   = 2;
    localparam int STREAM_W = 1;
    localparam int WORD_W   = 64;

    localparam logic [POS_W-1:0] WORDS    = 9'd312;
    localparam logic [POS_W-1:0] MID      = 9'd156;
    localparam logic [POS_W-1:0] UNSEEDED = 9'd313;

    localparam logic [MODE_W-1:0] MODE_SEED   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DRAW64 = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DRAW63 = 2'd2;

    localparam logic [WORD_W-1:0] TWIST_MATRIX = 64'hB502_6F5A_A966_19E9;
    localparam logic [WORD_W-1:0] UPPER_MASK   = 64'hFFFF_FFFF_8000_0000;
    localparam logic [WORD_W-1:0] LOWER_MASK   = 64'h0000_0000_7FFF_FFFF;
    localparam logic [WORD_W-1:0] DEFAULT_SEED = 64'd5489;
    localparam logic [31:0]       SEED_MULT_LO = 32'h4C95_7F2D;
    localparam logic [31:0]       SEED_MULT_HI = 32'h5851_F42D;

    localparam logic [WORD_W-1:0] TEMPER_B = 64'h5555_5555_5555_5555;
    localparam logic [WORD_W-1:0] TEMPER_C = 64'h71D6_7FFF_EDA6_0000;
    localparam logic [WORD_W-1:0] TEMPER_D = 64'hFFF7_EEE0_0000_0000;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_SEED_START,
        OP_SEED_MUL,
        OP_SEED_WR,
        OP_TW_PRIME,
        OP_TW_LOAD,
        OP_TW_RD,
        OP_TW_WR,
        OP_DR_OUT
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SEED_START,
        ST_SEED_MUL,
        ST_SEED_WR,
        ST_TW_PRIME,
        ST_TW_LOAD,
        ST_TW_RD,
        ST_TW_WR,
        ST_DR_RD,
        ST_DR_OUT
    } state_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic item_ok;
        logic is_seed;
        logic unseeded;
        logic twist_due;
        logic cnt_last;
        logic out_busy;
    } status_t;

    function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] x_in);
        logic [WORD_W-1:0] x;
        begin
            x = x_in;
            x = x ^ ((x >> 29) & TEMPER_B);
            x = x ^ ((x << 17) & TEMPER_C);
            x = x ^ ((x << 37) & TEMPER_D);
            x = x ^ (x >> 43);
            return x;
        end
    endfunction

endpackage

[design/mt64_ram.sv]
// Generic single-write, dual-read RAM with registered read data
`timescale 1ns / 1ps

module mt64_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 624
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a_reg <= mem_reg[raddr_a];
        rdata_b_reg <= mem_reg[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

[design/mt64_ctrl.sv]
// Controller state machine: sequences seeding, twisting and drawing
`timescale 1ns / 1ps

module mt64_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  mt64_pkg::status_t status,
    output mt64_pkg::cmd_t    cmd
);

    mt64_pkg::state_t state_reg;
    mt64_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mt64_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd.op     = mt64_pkg::OP_NONE;
        s_ready    = 1'b0;
        case (state_reg)
            mt64_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = mt64_pkg::OP_CAPTURE;
                    state_next = mt64_pkg::ST_DECODE;
                end
            end
            mt64_pkg::ST_DECODE: begin
                // drop unused modes and absent streams
                if (!status.item_ok) begin
                    state_next = mt64_pkg::ST_IDLE;
                end else if (status.is_seed || status.unseeded) begin
                    state_next = mt64_pkg::ST_SEED_START;
                end else if (status.twist_due) begin
                    state_next = mt64_pkg::ST_TW_PRIME;
                end else begin
                    state_next = mt64_pkg::ST_DR_RD;
                end
            end
            mt64_pkg::ST_SEED_START: begin
                cmd.op     = mt64_pkg::OP_SEED_START;
                state_next = mt64_pkg::ST_SEED_MUL;
            end
            mt64_pkg::ST_SEED_MUL: begin
                cmd.op     = mt64_pkg::OP_SEED_MUL;
                state_next = mt64_pkg::ST_SEED_WR;
            end
            mt64_pkg::ST_SEED_WR: begin
                cmd.op = mt64_pkg::OP_SEED_WR;
                if (!status.cnt_last) begin
                    state_next = mt64_pkg::ST_SEED_MUL;
                end else if (status.is_seed) begin
                    state_next = mt64_pkg::ST_IDLE;
                end else begin
                    state_next = mt64_pkg::ST_TW_PRIME;
                end
            end
            mt64_pkg::ST_TW_PRIME: begin
                cmd.op     = mt64_pkg::OP_TW_PRIME;
                state_next = mt64_pkg::ST_TW_LOAD;
            end
            mt64_pkg::ST_TW_LOAD: begin
                cmd.op     = mt64_pkg::OP_TW_LOAD;
                state_next = mt64_pkg::ST_TW_RD;
            end
            mt64_pkg::ST_TW_RD: begin
                cmd.op     = mt64_pkg::OP_TW_RD;
                state_next = mt64_pkg::ST_TW_WR;
            end
            mt64_pkg::ST_TW_WR: begin
                cmd.op     = mt64_pkg::OP_TW_WR;
                state_next = status.cnt_last ? mt64_pkg::ST_DR_RD : mt64_pkg::ST_TW_RD;
            end
            mt64_pkg::ST_DR_RD: begin
                state_next = mt64_pkg::ST_DR_OUT;
            end
            mt64_pkg::ST_DR_OUT: begin
                // hold the read word until the output register is free
                if (!status.out_busy) begin
                    cmd.op     = mt64_pkg::OP_DR_OUT;
                    state_next = mt64_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mt64_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[design/mt64_datapath.sv]
// Datapath: state memory, read positions, seeding multiplier, twist and temper
`timescale 1ns / 1ps

module mt64_datapath #(
    parameter int NUM_STREAMS = mt64_pkg::DEF_NUM_STREAMS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mt64_pkg::cmd_t                cmd,
    output mt64_pkg::status_t             status,
    input  logic [mt64_pkg::MODE_W-1:0]   s_mode,
    input  logic [mt64_pkg::STREAM_W-1:0] s_stream,
    input  logic [mt64_pkg::WORD_W-1:0]   s_seed_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mt64_pkg::WORD_W-1:0]   m_random_word
);

    localparam int DEPTH  = NUM_STREAMS * 312;
    localparam int AW     = $clog2(DEPTH);
    localparam int SIDX_W = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;

    logic [mt64_pkg::MODE_W-1:0]   mode_reg;
    logic [mt64_pkg::STREAM_W-1:0] stream_reg;
    logic [mt64_pkg::WORD_W-1:0]   seed_reg;
    logic [mt64_pkg::POS_W-1:0]    pos_reg [NUM_STREAMS];
    logic [mt64_pkg::POS_W-1:0]    cnt_reg;
    logic [mt64_pkg::WORD_W-1:0]   chain_reg;
    logic [63:0]                   p0_reg;
    logic [31:0]                   p1_reg;
    logic [31:0]                   p2_reg;
    logic [mt64_pkg::WORD_W-1:0]   cur_reg;
    logic [mt64_pkg::WORD_W-1:0]   out_reg;
    logic                          m_valid_reg;
    logic                          m_valid_next;

    logic [SIDX_W-1:0]             sidx;
    logic [AW-1:0]                 base;
    logic [mt64_pkg::POS_W-1:0]    pos_cur;
    logic [mt64_pkg::POS_W-1:0]    cnt_succ;
    logic [mt64_pkg::POS_W-1:0]    cnt_mid;
    logic                          cnt_last;
    logic [mt64_pkg::WORD_W-1:0]   first_word;
    logic [mt64_pkg::WORD_W-1:0]   seed_word;
    logic [mt64_pkg::WORD_W-1:0]   twist_y;
    logic [mt64_pkg::WORD_W-1:0]   twist_word;
    logic [mt64_pkg::WORD_W-1:0]   tempered;
    logic [mt64_pkg::WORD_W-1:0]   result_next;
    logic [63:0]                   p0_next;
    logic [31:0]                   p1_next;
    logic [31:0]                   p2_next;

    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [mt64_pkg::WORD_W-1:0]   ram_wdata;
    logic [AW-1:0]                 ram_raddr_a;
    logic [AW-1:0]                 ram_raddr_b;
    logic [mt64_pkg::WORD_W-1:0]   ram_rdata_a;
    logic [mt64_pkg::WORD_W-1:0]   ram_rdata_b;

    assign sidx     = SIDX_W'(stream_reg);
    assign base     = stream_reg[0] ? AW'(mt64_pkg::WORDS) : '0;
    assign pos_cur  = pos_reg[sidx];
    assign cnt_last = (cnt_reg == mt64_pkg::WORDS - 9'd1);
    assign cnt_succ = cnt_last ? '0 : cnt_reg + 9'd1;
    assign cnt_mid  = (cnt_reg < mt64_pkg::MID) ? cnt_reg + mt64_pkg::MID
                                                : cnt_reg - mt64_pkg::MID;

    // seeding recurrence: low 64 bits of the product from three 32-bit partials
    assign first_word = (mode_reg == mt64_pkg::MODE_SEED) ? seed_reg : mt64_pkg::DEFAULT_SEED;
    assign p0_next    = chain_reg[31:0] * mt64_pkg::SEED_MULT_LO;
    assign p1_next    = chain_reg[31:0] * mt64_pkg::SEED_MULT_HI;
    assign p2_next    = chain_reg[63:32] * mt64_pkg::SEED_MULT_LO;
    assign seed_word  = p0_reg + {p1_reg + p2_reg, 32'h0} + 64'(cnt_reg);

    // twist of one word: cur_reg is w[i], port a w[i+1], port b w[i+156]
    assign twist_y    = (cur_reg & mt64_pkg::UPPER_MASK) | (ram_rdata_a & mt64_pkg::LOWER_MASK);
    assign twist_word = ram_rdata_b ^ (twist_y >> 1) ^
                        (twist_y[0] ? mt64_pkg::TWIST_MATRIX : '0);

    assign tempered    = mt64_pkg::temper(ram_rdata_a);
    assign result_next = (mode_reg == mt64_pkg::MODE_DRAW63) ? (tempered >> 1) : tempered;

    always_comb begin
        case (cmd.op)
            mt64_pkg::OP_TW_PRIME: ram_raddr_a = base;
            mt64_pkg::OP_TW_RD:    ram_raddr_a = base + AW'(cnt_succ);
            default:               ram_raddr_a = base + AW'(pos_cur);
        endcase
    end
    assign ram_raddr_b = base + AW'(cnt_mid);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = base + AW'(cnt_reg);
        ram_wdata = seed_word;
        case (cmd.op)
            mt64_pkg::OP_SEED_START: begin
                ram_we    = 1'b1;
                ram_waddr = base;
                ram_wdata = first_word;
            end
            mt64_pkg::OP_SEED_WR: begin
                ram_we = 1'b1;
            end
            mt64_pkg::OP_TW_WR: begin
                ram_we    = 1'b1;
                ram_wdata = twist_word;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    mt64_ram #(
        .WIDTH (mt64_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

    // drop the result item once taken, load a new one on a draw
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (cmd.op == mt64_pkg::OP_DR_OUT) begin
            m_valid_next = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_STREAMS; i++) begin
                pos_reg[i] <= mt64_pkg::UNSEEDED;
            end
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            case (cmd.op)
                mt64_pkg::OP_SEED_START: begin
                    cnt_reg <= 9'd1;
                end
                mt64_pkg::OP_SEED_WR: begin
                    cnt_reg <= cnt_succ;
                    if (cnt_last) begin
                        pos_reg[sidx] <= mt64_pkg::WORDS;
                    end
                end
                mt64_pkg::OP_TW_PRIME: begin
                    cnt_reg <= '0;
                end
                mt64_pkg::OP_TW_WR: begin
                    cnt_reg <= cnt_succ;
                    if (cnt_last) begin
                        pos_reg[sidx] <= '0;
                    end
                end
                mt64_pkg::OP_DR_OUT: begin
                    pos_reg[sidx] <= pos_cur + 9'd1;
                end
                default: begin
                    cnt_reg <= cnt_reg;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            mt64_pkg::OP_CAPTURE: begin
                mode_reg   <= s_mode;
                stream_reg <= s_stream;
                seed_reg   <= s_seed_value;
            end
            mt64_pkg::OP_SEED_START: begin
                chain_reg <= first_word ^ (first_word >> 62);
            end
            mt64_pkg::OP_SEED_MUL: begin
                p0_reg <= p0_next;
                p1_reg <= p1_next;
                p2_reg <= p2_next;
            end
            mt64_pkg::OP_SEED_WR: begin
                chain_reg <= seed_word ^ (seed_word >> 62);
            end
            mt64_pkg::OP_TW_LOAD, mt64_pkg::OP_TW_WR: begin
                cur_reg <= ram_rdata_a;
            end
            mt64_pkg::OP_DR_OUT: begin
                out_reg <= result_next;
            end
            default: begin
                out_reg <= out_reg;
            end
        endcase
    end

    always_comb begin
        status.item_ok   = (mode_reg inside {mt64_pkg::MODE_SEED, mt64_pkg::MODE_DRAW64,
                                             mt64_pkg::MODE_DRAW63}) &&
                           (32'(stream_reg) < NUM_STREAMS);
        status.is_seed   = (mode_reg == mt64_pkg::MODE_SEED);
        status.unseeded  = (pos_cur == mt64_pkg::UNSEEDED);
        status.twist_due = (pos_cur >= mt64_pkg::WORDS);
        status.cnt_last  = cnt_last;
        status.out_busy  = m_valid_reg && !m_ready;
    end

    assign m_valid       = m_valid_reg;
    assign m_random_word = out_reg;

endmodule

[design/mersenne_twister_64_generator_core.sv]
// Top level of the multi-stream 64-bit twister generator
`timescale 1ns / 1ps

// Multi-stream 64-bit Mersenne Twister (mt19937_64) generator.
// Input channel s_*: one item per handshake; s_mode selects seed (no result),
// draw of a 64-bit word, or draw of the word shifted right by one; s_stream
// picks the stream. Unused mode or an absent stream is dropped without result.
// Output channel m_*: one m_random_word per draw item, in item order.
// Items are handled one at a time; s_ready is high only while the block is idle.
// Steps, from the accepting edge to m_valid:
//   plain draw: ST_DECODE, ST_DR_RD, then ST_DR_OUT loads the output register.
//   draw that needs a twist: ST_TW_PRIME and ST_TW_LOAD, then a read step and a
//   write step per state word, set by the two-read, one-write memory port plan.
//   seed item: busy with a step for the partial products and a step for the
//   sum and write per word; a draw from an unseeded stream adds this before
//   its twist.
// After reset every stream is unseeded and no result is pending; the state
// memory needs no clearing pass.
// A stalled receiver holds the result in the output register; the block still
// takes the next item, and a further draw waits for the register to empty.
module mersenne_twister_64_generator_core #(
    parameter int NUM_STREAMS = mt64_pkg::DEF_NUM_STREAMS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [mt64_pkg::MODE_W-1:0]   s_mode,
    input  logic [mt64_pkg::STREAM_W-1:0] s_stream,
    input  logic [mt64_pkg::WORD_W-1:0]   s_seed_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mt64_pkg::WORD_W-1:0]   m_random_word
);

    mt64_pkg::cmd_t    cmd;
    mt64_pkg::status_t status;

    mt64_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mt64_datapath #(
        .NUM_STREAMS (NUM_STREAMS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_mode        (s_mode),
        .s_stream      (s_stream),
        .s_seed_value  (s_seed_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_random_word (m_random_word)
    );

endmodule

[design/mt64_checker.sv]
// Port-level checker for the generator top level, with its bind
`timescale 1ns / 1ps
`include "mersenne_twister_64_generator_core_defines.svh"

module mt64_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [63:0] m_random_word
);

    `MT64_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_random_word), "stalled result item changed")
    `MT64_ASSERT_RST(a_reset_clears, aclk, !aresetn, !m_valid, "result valid after reset")
    `MT64_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready, "ready straight after an accepted item")
    `MT64_ASSERT_IMP(a_result_idle, aclk, aresetn, $rose(m_valid), s_ready, "new result without return to idle")

endmodule

bind mersenne_twister_64_generator_core mt64_checker u_mt64_checker (.*);

[tb/tb_mersenne_twister_64_generator_core.sv]
// Self-checking testbench: seeded and unseeded draws on both streams, compared with a predictor
`timescale 1ns / 1ps

module tb_mersenne_twister_64_generator_core;
    import mt64_pkg::*;

    localparam int STREAMS      = DEF_NUM_STREAMS;
    localparam int WORD_COUNT   = int'(WORDS);
    localparam int HALF_COUNT   = int'(MID);
    localparam int RANDOM_ITEMS = 600;
    localparam int STALL_LIMIT  = 8000;
    localparam int TAIL_CYCLES  = 1400;
    localparam int HOLD_AT      = 120;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_AT     = 400;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam logic [WORD_W-1:0] SEED_FACTOR = {SEED_MULT_HI, SEED_MULT_LO};

    class word_scoreboard;
        bit [WORD_W-1:0] state_words [STREAMS*WORD_COUNT];
        bit [POS_W-1:0]  read_pos [STREAMS];
        bit [WORD_W-1:0] expected_words [$];
        int errors;

        function new();
            int s;
            errors = 0;
            for (s = 0; s < STREAMS; s++) read_pos[s] = UNSEEDED;
        endfunction

        function void fill_from_seed(int s, bit [WORD_W-1:0] seed);
            int base;
            int i;
            bit [WORD_W-1:0] prev;
            base = s * WORD_COUNT;
            state_words[base] = seed;
            for (i = 1; i < WORD_COUNT; i++) begin
                prev = state_words[base + i - 1];
                state_words[base + i] = SEED_FACTOR * (prev ^ (prev >> 62)) + 64'(i);
            end
            read_pos[s] = WORDS;
        endfunction

        function void note_item(logic [MODE_W-1:0] mode, logic [STREAM_W-1:0] stream,
                                logic [WORD_W-1:0] seed_value);
            int s;
            int base;
            int i;
            bit [WORD_W-1:0] y;
            bit [WORD_W-1:0] x;
            s = int'(stream);
            if (s >= STREAMS || mode == MODE_UNUSED) return;
            if (mode == MODE_SEED) begin
                fill_from_seed(s, seed_value);
                return;
            end
            base = s * WORD_COUNT;
            if (read_pos[s] >= WORDS) begin
                // an untouched stream falls back to the default seed before its twist
                if (read_pos[s] != WORDS) fill_from_seed(s, DEFAULT_SEED);
                for (i = 0; i < WORD_COUNT; i++) begin
                    y = (state_words[base + i] & UPPER_MASK)
                        | (state_words[base + (i + 1) % WORD_COUNT] & LOWER_MASK);
                    state_words[base + i] = state_words[base + (i + HALF_COUNT) % WORD_COUNT]
                                            ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : '0);
                end
                read_pos[s] = '0;
            end
            x = state_words[base + int'(read_pos[s])];
            x = x ^ ((x >> 29) & TEMPER_B);
            x = x ^ ((x << 17) & TEMPER_C);
            x = x ^ ((x << 37) & TEMPER_D);
            x = x ^ (x >> 43);
            read_pos[s] = read_pos[s] + 1'b1;
            expected_words.push_back((mode == MODE_DRAW63) ? (x >> 1) : x);
        endfunction

        function void check_word(logic [WORD_W-1:0] got);
            bit [WORD_W-1:0] want;
            if (expected_words.size() == 0) begin
                errors++;
                if (errors <= 10) $display("%0t: unexpected word %h", $realtime, got);
                return;
            end
            want = expected_words.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: random_word mismatch: expected %h, got %h",
                             $realtime, want, got);
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [MODE_W-1:0]   s_mode;
    logic [STREAM_W-1:0] s_stream;
    logic [WORD_W-1:0]   s_seed_value;
    logic                m_valid;
    logic                m_ready;
    logic [WORD_W-1:0]   m_random_word;

    word_scoreboard sb;
    bit calm;
    int results_seen;

    mersenne_twister_64_generator_core #(
        .NUM_STREAMS(STREAMS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_mode(s_mode),
        .s_stream(s_stream),
        .s_seed_value(s_seed_value),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_random_word(m_random_word)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken
    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [STREAM_W-1:0] stream,
                             input logic [WORD_W-1:0] seed, input bit drain);
        int idle_cycles;
        idle_cycles = (!calm && $urandom_range(99) < 9) ? $urandom_range(1, 6) : 0;
        if (idle_cycles > 0 || (drain && sb.pending() != 0)) begin
            s_valid <= 1'b0;
            repeat (idle_cycles) @(negedge aclk);
            while (drain && sb.pending() != 0) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_mode       <= mode;
        s_stream     <= stream;
        s_seed_value <= seed;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(mode, stream, seed);
        @(negedge aclk);
    endtask

    initial begin
        int counted;
        int pick;
        logic [MODE_W-1:0]   mode;
        logic [STREAM_W-1:0] stream;
        logic [WORD_W-1:0]   seed;
        sb = new();
        calm = 1'b0;
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_mode       <= MODE_SEED;
        s_stream     <= '0;
        s_seed_value <= '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // draws from streams that were never seeded
        send_item(MODE_DRAW64, 1'b0, rand_word(), 1'b0);
        send_item(MODE_DRAW63, 1'b0, rand_word(), 1'b0);
        send_item(MODE_UNUSED, 1'b0, rand_word(), 1'b0);
        send_item(MODE_DRAW63, 1'b1, rand_word(), 1'b0);
        // seed extremes
        send_item(MODE_SEED,   1'b1, '0, 1'b0);
        send_item(MODE_DRAW64, 1'b1, '1, 1'b0);
        send_item(MODE_SEED,   1'b1, '1, 1'b0);
        send_item(MODE_DRAW63, 1'b1, '0, 1'b0);
        send_item(MODE_DRAW64, 1'b1, rand_word(), 1'b0);
        // explicit default seed must replay the unseeded sequence
        send_item(MODE_SEED,   1'b0, DEFAULT_SEED, 1'b0);
        send_item(MODE_DRAW64, 1'b0, rand_word(), 1'b0);
        send_item(MODE_UNUSED, 1'b1, rand_word(), 1'b0);
        send_item(MODE_DRAW64, 1'b0, rand_word(), 1'b0);
        // back-to-back seeds, the second overrides the first
        send_item(MODE_SEED,   1'b1, 64'h8000_0000_0000_0001, 1'b0);
        send_item(MODE_SEED,   1'b1, rand_word(), 1'b0);
        send_item(MODE_DRAW64, 1'b1, rand_word(), 1'b0);
        send_item(MODE_DRAW63, 1'b0, '1, 1'b0);

        // stream 0 is never reseeded here so it runs past a second twist
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            calm = (counted >= 150 && counted < 280);
            pick = $urandom_range(99);
            if (pick < 5)       mode = MODE_UNUSED;
            else if (pick < 9)  mode = MODE_SEED;
            else if (pick < 55) mode = MODE_DRAW64;
            else                mode = MODE_DRAW63;
            if (mode == MODE_SEED) stream = 1'b1;
            else if (mode == MODE_UNUSED) stream = STREAM_W'($urandom_range(1));
            else stream = ($urandom_range(99) < 65) ? 1'b0 : 1'b1;
            pick = $urandom_range(15);
            if (pick == 0)      seed = '0;
            else if (pick == 1) seed = '1;
            else if (pick == 2) seed = DEFAULT_SEED;
            else                seed = rand_word();
            send_item(mode, stream, seed, counted == DRAIN_AT);
            if (mode != MODE_UNUSED) counted++;
        end
        calm = 1'b0;
        s_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Result side: random back-pressure plus one long hold to fill the block
    initial begin
        int hold_left;
        bit held;
        hold_left = 0;
        held = 1'b0;
        m_ready <= 1'b0;
        forever begin
            @(negedge aclk);
            if (!held && results_seen >= HOLD_AT) begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= calm || ($urandom_range(99) >= 9);
            end
        end
    end

    initial begin
        results_seen = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                sb.check_word(m_random_word);
                results_seen++;
            end
        end
    end

    initial begin
        int idle_run;
        idle_run = 0;
        while (idle_run < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_run = 0;
            else idle_run++;
        end
        $display("TEST FAILED");
        $finish;
    end

endmodule
